// ----- rtl/core/srle_pkg.sv -----
// Package for the sprite row run-length encoder.
// Holds shared sizes, register indexes, mode codes and the command and status
// structs used between the controller and the datapath. No dependencies.
package srle_pkg;

   localparam int MAX_WIDTH  = 4096;
   localparam int MAX_HEIGHT = 4096;
   localparam int RUN_MAX    = 127;

   localparam int SIZE_W  = 13;
   localparam int INDEX_W = 12;
   localparam int RUN_W   = 7;
   localparam int WORD_W  = 16;
   localparam int CSR_W   = 16;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_ENCODE_MODE     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_COLOR       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GREEN_FIVE_BITS = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT    = 3'd4;

   localparam logic [1:0] MODE_KEYED   = 2'd0;
   localparam logic [1:0] MODE_OPAQUE  = 2'd1;
   localparam logic [1:0] MODE_PREMULT = 2'd2;
   localparam logic [1:0] MODE_INVERSE = 2'd3;

   typedef enum logic [2:0] {
      BSEL_COUNT     = 3'd0,
      BSEL_LO        = 3'd1,
      BSEL_HI        = 3'd2,
      BSEL_ZERO      = 3'd3,
      BSEL_EMPTY_ROW = 3'd4
   } byte_sel_type;

   typedef struct packed {
      logic         load_pixel;
      logic         store;
      logic         flush_start;
      logic         idx_inc;
      logic         run_clear;
      logic         push;
      byte_sel_type byte_sel;
      logic         col_inc;
      logic         row_end;
      logic         final_emit;
   } cmd_type;

   typedef struct packed {
      logic run_len_zero;
      logic class_differs;
      logic run_will_fill;
      logic run_literal;
      logic end_of_row;
      logic empty_row;
      logic idx_last;
      logic mode_inverse;
      logic byte_ok;
      logic out_free;
      logic pack_empty;
   } status_type;

endpackage

// ----- rtl/core/srle_if.sv -----
// Channel interfaces for the sprite row run-length encoder.
// The pixel channel and the result channel; no dependencies.
interface srle_pix_if;
   logic        valid;
   logic        ready;
   logic [31:0] pixel;
   modport source (output valid, output pixel, input ready);
   modport sink   (input valid, input pixel, output ready);
endinterface

interface srle_out_if;
   logic        valid;
   logic        ready;
   logic [31:0] out_bytes;
   logic [2:0]  byte_count;
   logic        last_of_item;
   logic        image_done;
   logic [31:0] body_size;
   modport source (output valid, output out_bytes, output byte_count, output last_of_item,
                   output image_done, output body_size, input ready);
   modport sink   (input valid, input out_bytes, input byte_count, input last_of_item,
                   input image_done, input body_size, output ready);
endinterface

// ----- rtl/core/srle_datapath.sv -----
// Datapath of the sprite row run-length encoder: configuration registers,
// pixel classing, run store memory, byte packer and output register.
// Depends on srle_pkg; driven by srle_controller through cmd_type.
module srle_datapath
   import srle_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_write_data,
   input  logic [31:0]          pixel,
   input  logic                 out_ready,
   input  cmd_type              cmd,
   output status_type           status,
   output logic                 out_valid,
   output logic [31:0]          out_bytes,
   output logic [2:0]           out_count,
   output logic                 out_last,
   output logic                 out_done,
   output logic [31:0]          out_body
);

   logic [1:0]        mode_ff;
   logic [WORD_W-1:0] key_ff;
   logic              g5_ff;
   logic [SIZE_W-1:0] width_ff, height_ff;

   logic              lit_ff;
   logic [WORD_W-1:0] word_ff;
   logic [INDEX_W-1:0] col_ff, row_ff;
   logic              done_ff;
   logic [RUN_W-1:0]  run_len_ff, idx_ff, idx_in;
   logic              run_lit_ff, started_ff;
   logic [WORD_W-1:0] mem [RUN_MAX];
   logic [WORD_W-1:0] rd_ff;

   logic [31:0] pack_ff;
   logic [2:0]  pack_cnt_ff;
   logic [31:0] body_ff;

   logic              out_valid_ff, out_last_ff, out_done_ff;
   logic [31:0]       out_bytes_ff, out_body_ff;
   logic [2:0]        out_count_ff;

   // Exact floor(v/63) for v below 4032: one correction step.
   function automatic logic [5:0] div63(input logic [11:0] v);
      logic [5:0] q0;
      logic [6:0] r;
      q0 = v[11:6];
      r  = {1'b0, v[5:0]} + {1'b0, q0};
      div63 = q0 + {5'd0, (r >= 7'd63)};
   endfunction

   logic [SIZE_W-1:0] w_eff, h_eff;
   always_comb begin
      if (width_ff == '0) w_eff = SIZE_W'(1);
      else if (width_ff > SIZE_W'(MAX_WIDTH)) w_eff = SIZE_W'(MAX_WIDTH);
      else w_eff = width_ff;
      if (height_ff == '0) h_eff = SIZE_W'(1);
      else if (height_ff > SIZE_W'(MAX_HEIGHT)) h_eff = SIZE_W'(MAX_HEIGHT);
      else h_eff = height_ff;
   end

   // Pixel classing and literal word.
   logic [5:0]  alpha;
   logic [4:0]  r5, b5;
   logic [5:0]  g6;
   logic [5:0]  rs, gs, bs;
   logic        lit_in;
   logic [WORD_W-1:0] word_in;
   always_comb begin
      alpha = pixel[31:26];
      r5 = pixel[23:19];
      b5 = pixel[7:3];
      g6 = g5_ff ? {1'b0, pixel[15:11]} : pixel[15:10];
      rs = {1'b0, r5};
      gs = g6;
      bs = {1'b0, b5};
      if (mode_ff == MODE_PREMULT) begin
         rs = div63(12'({6'd0, rs} * {6'd0, alpha}));
         gs = div63(12'({6'd0, gs} * {6'd0, alpha}));
         bs = div63(12'({6'd0, bs} * {6'd0, alpha}));
      end
      case (mode_ff)
         MODE_KEYED:  lit_in = pixel[15:0] != key_ff;
         MODE_OPAQUE: lit_in = alpha == 6'd63;
         default:     lit_in = (alpha != 6'd0) && (alpha != 6'd63);
      endcase
      case (mode_ff)
         MODE_KEYED:   word_in = pixel[15:0];
         MODE_INVERSE: word_in = {10'd0, 6'd63 - alpha};
         default: begin
            if (g5_ff) word_in = {1'b0, rs[4:0], gs[4:0], bs[4:0]};
            else       word_in = {rs[4:0], gs, bs[4:0]};
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_KEYED;
         key_ff    <= '0;
         g5_ff     <= 1'b0;
         width_ff  <= SIZE_W'(1);
         height_ff <= SIZE_W'(1);
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_ENCODE_MODE:     mode_ff   <= csr_write_data[1:0];
            CSR_KEY_COLOR:       key_ff    <= csr_write_data;
            CSR_GREEN_FIVE_BITS: g5_ff     <= csr_write_data[0];
            CSR_IMAGE_WIDTH:     width_ff  <= csr_write_data[SIZE_W-1:0];
            CSR_IMAGE_HEIGHT:    height_ff <= csr_write_data[SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_pixel) begin
         lit_ff  <= lit_in;
         word_ff <= word_in;
      end
   end

   // Run store: write at the run length, read at the flush index.
   always_comb begin
      idx_in = idx_ff;
      if (cmd.flush_start) idx_in = '0;
      else if (cmd.idx_inc) idx_in = idx_ff + RUN_W'(1);
   end

   always_ff @(posedge clock) begin
      if (cmd.store) mem[run_len_ff] <= word_ff;
      rd_ff <= mem[idx_in];
   end

   logic [SIZE_W-1:0] col_next, row_next;
   assign col_next = {1'b0, col_ff} + SIZE_W'(1);
   assign row_next = {1'b0, row_ff} + SIZE_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         done_ff    <= 1'b0;
         run_len_ff <= '0;
         run_lit_ff <= 1'b0;
         started_ff <= 1'b0;
         idx_ff     <= '0;
      end else begin
         idx_ff <= idx_in;
         if (cmd.load_pixel) done_ff <= 1'b0;
         if (cmd.store) begin
            if (run_len_ff == '0) begin
               run_lit_ff <= lit_ff;
               started_ff <= col_ff == '0;
            end
            run_len_ff <= run_len_ff + RUN_W'(1);
         end
         if (cmd.run_clear) run_len_ff <= '0;
         if (cmd.col_inc) col_ff <= col_next[INDEX_W-1:0];
         if (cmd.row_end) begin
            col_ff <= '0;
            if (row_next >= h_eff) begin
               row_ff  <= '0;
               done_ff <= 1'b1;
            end else begin
               row_ff <= row_next[INDEX_W-1:0];
            end
         end
      end
   end

   // Byte packer and output register.
   logic [7:0]  push_byte;
   logic        out_free;
   logic [32:0] body_sum;
   logic [31:0] body_sat;
   always_comb begin
      case (cmd.byte_sel)
         BSEL_COUNT:     push_byte = {run_lit_ff, run_len_ff};
         BSEL_LO:        push_byte = rd_ff[7:0];
         BSEL_HI:        push_byte = rd_ff[15:8];
         BSEL_EMPTY_ROW: push_byte = 8'h80;
         default:        push_byte = 8'h00;
      endcase
      out_free = !out_valid_ff || out_ready;
      body_sum = {1'b0, body_ff} + {30'd0, pack_cnt_ff};
      body_sat = body_sum[32] ? 32'hFFFF_FFFF : body_sum[31:0];
   end

   logic emit_full, emit_final;
   assign emit_full  = cmd.push && (pack_cnt_ff == 3'd4);
   assign emit_final = cmd.final_emit && (pack_cnt_ff != 3'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         pack_ff      <= '0;
         pack_cnt_ff  <= '0;
         body_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (emit_full || emit_final) begin
            out_valid_ff <= 1'b1;
            out_bytes_ff <= pack_ff;
            out_count_ff <= pack_cnt_ff;
            out_last_ff  <= emit_final;
            out_done_ff  <= emit_final && done_ff;
            out_body_ff  <= body_sat;
            // The byte count starts over once the image is complete.
            body_ff      <= (emit_final && done_ff) ? '0 : body_sat;
         end else if (out_valid_ff && out_ready) begin
            out_valid_ff <= 1'b0;
         end
         if (cmd.push) begin
            if (pack_cnt_ff == 3'd4) begin
               pack_ff     <= {24'd0, push_byte};
               pack_cnt_ff <= 3'd1;
            end else begin
               pack_ff[{pack_cnt_ff[1:0], 3'b000} +: 8] <= push_byte;
               pack_cnt_ff <= pack_cnt_ff + 3'd1;
            end
         end
         if (cmd.final_emit) begin
            pack_ff     <= '0;
            pack_cnt_ff <= '0;
         end
      end
   end

   always_comb begin
      status.run_len_zero  = run_len_ff == '0;
      status.class_differs = lit_ff != run_lit_ff;
      status.run_will_fill = run_len_ff == RUN_W'(RUN_MAX - 1);
      status.run_literal   = run_lit_ff;
      status.end_of_row    = col_next >= w_eff;
      status.empty_row     = (run_len_ff != '0) && !run_lit_ff && started_ff
                             && (w_eff < SIZE_W'(RUN_MAX));
      status.idx_last      = (idx_ff + RUN_W'(1)) == run_len_ff;
      status.mode_inverse  = mode_ff == MODE_INVERSE;
      status.byte_ok       = (pack_cnt_ff != 3'd4) || out_free;
      status.out_free      = out_free;
      status.pack_empty    = pack_cnt_ff == 3'd0;
   end

   assign out_valid = out_valid_ff;
   assign out_bytes = out_bytes_ff;
   assign out_count = out_count_ff;
   assign out_last  = out_last_ff;
   assign out_done  = out_done_ff;
   assign out_body  = out_body_ff;

endmodule

// ----- rtl/core/srle_controller.sv -----
// Controller of the sprite row run-length encoder: sequences classing, run
// storage, run flushes, end-of-row bytes and the final result of each item.
// Depends on srle_pkg; commands srle_datapath through cmd_type.
module srle_controller
   import srle_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_CHECK = 9'b000000010,
      ST_STORE = 9'b000000100,
      ST_EOR   = 9'b000001000,
      ST_ZERO  = 9'b000010000,
      ST_FINAL = 9'b000100000,
      ST_F_CNT = 9'b001000000,
      ST_F_LO  = 9'b010000000,
      ST_F_HI  = 9'b100000000
   } state_type;

   state_type state_ff, state_in, ret_ff, ret_in;
   logic      sel128_ff, sel128_in;

   always_comb begin
      state_in  = state_ff;
      ret_in    = ret_ff;
      sel128_in = sel128_ff;
      cmd       = '0;
      cmd.byte_sel = BSEL_ZERO;
      in_ready  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd.load_pixel = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (!status.run_len_zero && status.class_differs) begin
               cmd.flush_start = 1'b1;
               ret_in   = ST_STORE;
               state_in = ST_F_CNT;
            end else begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            cmd.store = 1'b1;
            if (status.run_will_fill) begin
               cmd.flush_start = 1'b1;
               ret_in   = ST_EOR;
               state_in = ST_F_CNT;
            end else begin
               state_in = ST_EOR;
            end
         end
         ST_EOR: begin
            sel128_in = 1'b0;
            if (!status.end_of_row) begin
               cmd.col_inc = 1'b1;
               state_in = ST_FINAL;
            end else if (status.empty_row) begin
               // A wholly transparent narrow row collapses to one marker byte.
               cmd.run_clear = 1'b1;
               sel128_in = 1'b1;
               state_in  = ST_ZERO;
            end else if (!status.run_len_zero) begin
               cmd.flush_start = 1'b1;
               ret_in   = ST_ZERO;
               state_in = ST_F_CNT;
            end else begin
               state_in = ST_ZERO;
            end
         end
         ST_ZERO: begin
            if (status.byte_ok) begin
               cmd.push     = 1'b1;
               cmd.byte_sel = sel128_ff ? BSEL_EMPTY_ROW : BSEL_ZERO;
               cmd.row_end  = 1'b1;
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            if (status.pack_empty || status.out_free) begin
               cmd.final_emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_F_CNT: begin
            if (status.byte_ok) begin
               cmd.push     = 1'b1;
               cmd.byte_sel = BSEL_COUNT;
               if (status.run_literal) begin
                  state_in = ST_F_LO;
               end else begin
                  cmd.run_clear = 1'b1;
                  state_in = ret_ff;
               end
            end
         end
         ST_F_LO: begin
            if (status.byte_ok) begin
               cmd.push     = 1'b1;
               cmd.byte_sel = BSEL_LO;
               if (!status.mode_inverse) begin
                  state_in = ST_F_HI;
               end else if (status.idx_last) begin
                  cmd.run_clear = 1'b1;
                  state_in = ret_ff;
               end else begin
                  cmd.idx_inc = 1'b1;
               end
            end
         end
         ST_F_HI: begin
            if (status.byte_ok) begin
               cmd.push     = 1'b1;
               cmd.byte_sel = BSEL_HI;
               if (status.idx_last) begin
                  cmd.run_clear = 1'b1;
                  state_in = ret_ff;
               end else begin
                  cmd.idx_inc = 1'b1;
                  state_in = ST_F_LO;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         ret_ff    <= ST_IDLE;
         sel128_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         ret_ff    <= ret_in;
         sel128_ff <= sel128_in;
      end
   end

endmodule

// ----- rtl/core/sprite_row_rle_encoder.sv -----
// Sprite row run-length encoder, one pixel item at a time.
// An item that flushes no run and ends no row passes through accept, check,
// store, row check and finish; a run flush or row end adds the push of each of its
// bytes, and the full packer waits on the output. A full packed word is moved to
// the output register when the next byte is pushed or the item finishes.
// Synchronous active-high reset clears control state; the run store holds
// no reset value and only entries written in the current run are read.
module sprite_row_rle_encoder
   import srle_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   srle_pix_if.sink             req_ch,
   srle_out_if.source           rsp_ch,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_write_data
);

   cmd_type    cmd;
   status_type status;

   srle_controller u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_ch.valid),
      .in_ready (req_ch.ready),
      .status   (status),
      .cmd      (cmd)
   );

   srle_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .pixel            (req_ch.pixel),
      .out_ready        (rsp_ch.ready),
      .cmd              (cmd),
      .status           (status),
      .out_valid        (rsp_ch.valid),
      .out_bytes        (rsp_ch.out_bytes),
      .out_count        (rsp_ch.byte_count),
      .out_last         (rsp_ch.last_of_item),
      .out_done         (rsp_ch.image_done),
      .out_body         (rsp_ch.body_size)
   );

endmodule

// ----- test/tb.sv -----
// Testbench for sprite_row_rle_encoder: a directed table, then random images in all modes.
// Results are checked field by field against a predictor of the run-length byte stream.
// Depends on srle_pkg, srle_if and the encoder RTL.
`timescale 1ns / 100ps

module tb
   import srle_pkg::*;
;

   typedef struct {
      logic [31:0] out_bytes;
      logic [2:0]  byte_count;
      logic        last_of_item;
      logic        image_done;
      logic [31:0] body_size;
   } rle_word_type;

   typedef struct {
      bit                   is_csr;
      logic [CSR_IDX_W-1:0] csr_idx;
      logic [31:0]          value;
      bit                   typed;
      logic [31:0]          want_bytes;
      logic [2:0]           want_count;
   } step_row_type;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0] csr_write_data;

   srle_pix_if req_if ();
   srle_out_if rsp_if ();

   sprite_row_rle_encoder uut (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_if),
      .rsp_ch           (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Shadow of the configuration registers.
   logic [1:0]  cfg_mode;
   logic [15:0] cfg_key;
   logic        cfg_g5;
   logic [12:0] cfg_width;
   logic [12:0] cfg_height;

   // Shadow of the encoder state.
   int unsigned col_pos, row_pos, run_len, body_total;
   bit run_literal, run_row_start;
   logic [15:0] run_words [RUN_MAX];
   logic [7:0]  byte_stream [$];

   rle_word_type expected_words [$];
   int n_errors = 0;
   bit hold_off_request = 0;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   initial begin
      #8ms;
      $display("tb: errors");
      $finish;
   end

   function automatic void flush_run_bytes();
      if (run_len == 0) return;
      byte_stream.push_back(8'(run_len) | (run_literal ? 8'h80 : 8'h00));
      if (run_literal) begin
         for (int i = 0; i < run_len; i++) begin
            byte_stream.push_back(run_words[i][7:0]);
            if (cfg_mode != MODE_INVERSE) byte_stream.push_back(run_words[i][15:8]);
         end
      end
      run_len = 0;
   endfunction

   function automatic void predict_encoding(logic [31:0] px);
      int unsigned w, h, a, r, g, b, cnt, nres;
      bit lit, done;
      logic [15:0] word;
      rle_word_type e;
      w = (cfg_width == 0) ? 1 : (cfg_width > MAX_WIDTH ? MAX_WIDTH : cfg_width);
      h = (cfg_height == 0) ? 1 : (cfg_height > MAX_HEIGHT ? MAX_HEIGHT : cfg_height);
      a = px[31:26];
      done = 0;
      byte_stream.delete();
      if (cfg_mode == MODE_KEYED) lit = px[15:0] != cfg_key;
      else if (cfg_mode == MODE_OPAQUE) lit = a == 63;
      else lit = a != 0 && a != 63;
      if (cfg_mode == MODE_KEYED) begin
         word = px[15:0];
      end else if (cfg_mode == MODE_INVERSE) begin
         word = 16'(63 - a);
      end else begin
         r = px[23:19];
         g = cfg_g5 ? px[15:11] : px[15:10];
         b = px[7:3];
         if (cfg_mode == MODE_PREMULT) begin
            r = r * a / 63;
            g = g * a / 63;
            b = b * a / 63;
         end
         word = 16'((cfg_g5 ? (r << 10) : (r << 11)) | (g << 5) | b);
      end
      if (run_len > 0 && lit != run_literal) flush_run_bytes();
      if (run_len == 0) begin
         run_literal = lit;
         run_row_start = col_pos == 0;
      end
      run_words[run_len] = word;
      run_len++;
      if (run_len >= RUN_MAX) flush_run_bytes();
      if (col_pos + 1 >= w) begin
         // A row that stayed transparent from its first pixel collapses to one byte.
         if (run_len > 0 && !run_literal && run_row_start && w < RUN_MAX) begin
            byte_stream.push_back(8'h80);
            run_len = 0;
         end else begin
            flush_run_bytes();
            byte_stream.push_back(8'h00);
         end
         col_pos = 0;
         row_pos++;
         if (row_pos >= h) begin
            row_pos = 0;
            done = 1;
         end
      end else begin
         col_pos++;
      end
      nres = (byte_stream.size() + 3) / 4;
      for (int k = 0; k < nres; k++) begin
         cnt = byte_stream.size() - 4 * k;
         if (cnt > 4) cnt = 4;
         e.out_bytes = '0;
         for (int i = 0; i < cnt; i++) e.out_bytes[8*i +: 8] = byte_stream[4*k + i];
         body_total = (body_total > 32'hFFFF_FFFF - cnt) ? 32'hFFFF_FFFF : body_total + cnt;
         e.byte_count = 3'(cnt);
         e.last_of_item = k + 1 == nres;
         e.image_done = done && k + 1 == nres;
         e.body_size = body_total;
         expected_words.push_back(e);
      end
      if (done) body_total = 0;
   endfunction

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [31:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value[CSR_W-1:0];
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_ENCODE_MODE:     cfg_mode = value[1:0];
         CSR_KEY_COLOR:       cfg_key = value[15:0];
         CSR_GREEN_FIVE_BITS: cfg_g5 = value[0];
         CSR_IMAGE_WIDTH:     cfg_width = value[12:0];
         CSR_IMAGE_HEIGHT:    cfg_height = value[12:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Lowers valid, waits for every expected result, then lets a silent item finish.
   task automatic wait_idle();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (expected_words.size() != 0);
      repeat (20) @(posedge clock);
   endtask

   bit send_burst = 0;

   task automatic send_pixel(logic [31:0] px);
      int gap;
      gap = send_burst ? 0 : $urandom_range(0, 12);
      if ($urandom_range(0, 15) == 0) send_burst = !send_burst;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.pixel <= px;
      do @(posedge clock); while (!req_if.ready);
      predict_encoding(px);
   endtask

   function automatic logic [31:0] make_pixel(bit lit);
      logic [31:0] px;
      px = $urandom;
      case (cfg_mode)
         MODE_KEYED: begin
            if (!lit) px[15:0] = cfg_key;
            else if (px[15:0] == cfg_key) px[0] = !px[0];
         end
         MODE_OPAQUE: px[31:26] = lit ? 6'd63 : 6'($urandom_range(0, 62));
         default: begin
            px[31:26] = lit ? 6'($urandom_range(1, 62))
                            : ($urandom_range(0, 1) ? 6'd63 : 6'd0);
         end
      endcase
      return px;
   endfunction

   step_row_type directed [] = '{
      '{0, CSR_ENCODE_MODE, 32'h0000_0000, 1, 32'h0000_0080, 3'd1},
      '{0, CSR_ENCODE_MODE, 32'h0000_1234, 1, 32'h0012_3481, 3'd4},
      '{0, CSR_ENCODE_MODE, 32'hFFFF_FFFF, 1, 32'h00FF_FF81, 3'd4},
      '{1, CSR_IMAGE_WIDTH, 32'd0, 0, 0, 0},
      '{0, CSR_ENCODE_MODE, 32'h0000_0005, 1, 32'h0000_0581, 3'd4},
      '{1, CSR_KEY_COLOR, 32'h0000_FFFF, 0, 0, 0},
      '{0, CSR_ENCODE_MODE, 32'hABCD_FFFF, 1, 32'h0000_0080, 3'd1},
      '{1, CSR_ENCODE_MODE, MODE_OPAQUE, 0, 0, 0},
      '{0, CSR_ENCODE_MODE, 32'hFC00_0000, 1, 32'h0000_0081, 3'd4},
      '{0, CSR_ENCODE_MODE, 32'h00FF_FFFF, 1, 32'h0000_0080, 3'd1},
      '{0, CSR_ENCODE_MODE, 32'hFFFF_FFFF, 0, 0, 0},
      '{1, CSR_ENCODE_MODE, MODE_INVERSE, 0, 0, 0},
      '{0, CSR_ENCODE_MODE, 32'h8000_0000, 1, 32'h0000_1F81, 3'd3},
      '{0, CSR_ENCODE_MODE, 32'hFFFF_FFFF, 1, 32'h0000_0080, 3'd1},
      '{0, CSR_ENCODE_MODE, 32'h0400_0000, 0, 0, 0},
      '{1, CSR_ENCODE_MODE, MODE_PREMULT, 0, 0, 0},
      '{1, CSR_GREEN_FIVE_BITS, 32'd1, 0, 0, 0},
      '{1, CSR_IMAGE_WIDTH, 32'd3, 0, 0, 0},
      '{1, CSR_IMAGE_HEIGHT, 32'd2, 0, 0, 0},
      '{0, CSR_ENCODE_MODE, 32'h80FF_FFFF, 0, 0, 0},
      '{0, CSR_ENCODE_MODE, 32'h0400_0000, 0, 0, 0},
      '{0, CSR_ENCODE_MODE, 32'h0000_0000, 0, 0, 0},
      '{0, CSR_ENCODE_MODE, 32'hFCFF_FFFF, 0, 0, 0},
      '{0, CSR_ENCODE_MODE, 32'h0000_0000, 0, 0, 0},
      '{0, CSR_ENCODE_MODE, 32'h0000_0000, 0, 0, 0},
      '{0, CSR_ENCODE_MODE, 32'h7B5A_A5C3, 0, 0, 0},
      '{0, CSR_ENCODE_MODE, 32'hF8A5_5A3C, 0, 0, 0},
      '{0, CSR_ENCODE_MODE, 32'h0800_0000, 0, 0, 0}
   };

   // One random phase: mode, green packing, width, height, item count, class toggle odds.
   int unsigned phases [][6] = '{
      '{MODE_KEYED,   0, 5,    3,    15, 4},
      '{MODE_OPAQUE,  0, 127,  1,    20, 400},
      '{MODE_PREMULT, 1, 130,  1,    50, 64},
      '{MODE_INVERSE, 0, 2,    4,    12, 3},
      '{MODE_PREMULT, 0, 126,  2,    10, 200},
      '{MODE_INVERSE, 1, 0,    0,    4,  2},
      '{MODE_KEYED,   1, 8191, 8191, 6,  3}
   };

   initial begin
      rle_word_type e;
      step_row_type row;
      bit lit;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      req_if.valid = 1'b0;
      req_if.pixel = '0;
      cfg_mode = MODE_KEYED;
      cfg_key = '0;
      cfg_g5 = 0;
      cfg_width = 1;
      cfg_height = 1;
      col_pos = 0;
      row_pos = 0;
      run_len = 0;
      body_total = 0;
      run_literal = 0;
      run_row_start = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) begin
         row = directed[i];
         if (row.is_csr) begin
            wait_idle();
            csr_write(row.csr_idx, row.value);
         end else begin
            send_pixel(row.value);
            if (row.typed) begin
               e = expected_words.pop_back();
               e.out_bytes = row.want_bytes;
               e.byte_count = row.want_count;
               expected_words.push_back(e);
            end
         end
      end

      foreach (phases[p]) begin
         wait_idle();
         csr_write(CSR_ENCODE_MODE, phases[p][0]);
         csr_write(CSR_KEY_COLOR, (p == 6) ? 32'hFFFF : $urandom_range(0, 65535));
         csr_write(CSR_GREEN_FIVE_BITS, phases[p][1]);
         csr_write(CSR_IMAGE_WIDTH, phases[p][2]);
         csr_write(CSR_IMAGE_HEIGHT, phases[p][3]);
         // The premultiplied five-bit-green phase makes the receiver hold off while pixels keep coming.
         if (p == 2) hold_off_request = 1;
         lit = $urandom_range(0, 1);
         for (int n = 0; n < phases[p][4]; n++) begin
            if ($urandom_range(1, phases[p][5]) == 1) lit = !lit;
            send_pixel(make_pixel(lit));
         end
      end

      req_if.valid <= 1'b0;
      do @(posedge clock); while (expected_words.size() != 0);
      repeat (50) @(posedge clock);
      if (n_errors == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

   // Result side: random stalls, one long hold-off on request, checks on every accepted result word.
   initial begin
      rle_word_type e;
      int stall;
      bit recv_burst;
      recv_burst = 0;
      rsp_if.ready = 1'b0;
      forever begin
         if (hold_off_request) begin
            rsp_if.ready <= 1'b0;
            repeat (600) @(posedge clock);
            hold_off_request = 0;
         end else begin
            stall = recv_burst ? 0 : $urandom_range(0, 12);
            if ($urandom_range(0, 15) == 0) recv_burst = !recv_burst;
            if (stall > 0) begin
               rsp_if.ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_if.valid && rsp_if.ready));
         if (expected_words.size() == 0) begin
            $error("unexpected result item: out_bytes %h", rsp_if.out_bytes);
            n_errors++;
         end else begin
            e = expected_words.pop_front();
            if (rsp_if.out_bytes !== e.out_bytes) begin
               $error("out_bytes: expected %h, got %h", e.out_bytes, rsp_if.out_bytes);
               n_errors++;
            end
            if (rsp_if.byte_count !== e.byte_count) begin
               $error("byte_count: expected %0d, got %0d", e.byte_count, rsp_if.byte_count);
               n_errors++;
            end
            if (rsp_if.last_of_item !== e.last_of_item) begin
               $error("last_of_item: expected %0b, got %0b", e.last_of_item,
                      rsp_if.last_of_item);
               n_errors++;
            end
            if (rsp_if.image_done !== e.image_done) begin
               $error("image_done: expected %0b, got %0b", e.image_done, rsp_if.image_done);
               n_errors++;
            end
            if (rsp_if.body_size !== e.body_size) begin
               $error("body_size: expected %0d, got %0d", e.body_size, rsp_if.body_size);
               n_errors++;
            end
         end
      end
   end

endmodule

// ----- filelist.f -----
rtl/core/srle_pkg.sv
rtl/core/srle_if.sv
rtl/core/srle_datapath.sv
rtl/core/srle_controller.sv
rtl/core/sprite_row_rle_encoder.sv
test/tb.sv
